// ===== sv/ipr_pkg.sv =====
// ipr_pkg: shared types and constants of the isolated pixel removal block
// pixel and line-memory word layout, item kinds, register indexes
// no dependencies
`default_nettype none

package ipr_pkg;

    localparam int PIX_W      = 16;
    localparam int WORD_W     = PIX_W + 1;
    localparam int CFG_W_W    = 6;
    localparam int CFG_H_W    = 11;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_W_W-1:0] RESET_WIDTH  = 6'd10;
    localparam logic [CFG_H_W-1:0] RESET_HEIGHT = 11'd10;

    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_FRAME_WIDTH  = 1'b0;
    localparam t_reg_idx REG_FRAME_HEIGHT = 1'b1;

    // kind of a step handed from the sequencer to the window stage
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_REAL  = 2'd0;
    localparam t_kind KIND_FLUSH = 2'd1;
    localparam t_kind KIND_END   = 2'd2;

    typedef struct packed {
        t_kind             kind;
        logic [PIX_W-1:0]  value;
        logic              top_ok;
        logic              mid_ok;
        logic              col_zero;
    } t_item;

    typedef struct packed {
        logic              top;
        logic              mid;
        logic              bot;
        logic [PIX_W-1:0]  value;
    } t_col;

    typedef struct packed {
        logic [PIX_W-1:0]  value;
        logic              removed;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/ipr_ram.sv =====
// ipr_ram: generic single-write, single-read synchronous memory
// read data is registered and holds while no read is issued
// no dependencies
`default_nettype none

module ipr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== sv/ipr_seq.sv =====
// ipr_seq: column and row counters, line-memory read issue, end-of-frame flush
// after the last pixel it issues one flush step per column and a closing step
// depends on ipr_pkg
`default_nettype none

module ipr_seq
    import ipr_pkg::*;
#(
    parameter int CW = 5,
    parameter int RW = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_restart,
    input  wire logic [CW-1:0]    i_w_last,
    input  wire logic [RW-1:0]    i_h_last,
    input  wire logic             i_in_valid,
    input  wire logic [PIX_W-1:0] i_pixel_value,
    input  wire logic             i_take,
    output logic                  o_issue,
    output t_item                 o_item,
    output logic [CW-1:0]         o_addr,
    output logic                  o_rd_en,
    output logic                  o_flushing
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic          h_ge2;

    assign h_ge2 = (i_h_last != '0);

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_row   = r_row;
        o_issue = 1'b0;
        o_item  = '0;
        case (r_state)
            ST_IDLE: begin
                o_issue         = i_take && i_in_valid;
                o_item.kind     = KIND_REAL;
                o_item.value    = i_pixel_value;
                o_item.top_ok   = (r_row > RW'(1));
                o_item.mid_ok   = (r_row != '0);
                o_item.col_zero = (r_col == '0);
                if (o_issue) begin
                    if (r_col == i_w_last) begin
                        n_col = '0;
                        if (r_row == i_h_last) begin
                            n_row   = '0;
                            n_state = ST_FLUSH;
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            ST_FLUSH: begin
                o_issue         = i_take;
                o_item.kind     = KIND_FLUSH;
                o_item.top_ok   = h_ge2;
                o_item.mid_ok   = 1'b1;
                o_item.col_zero = (r_col == '0);
                if (o_issue) begin
                    if (r_col == i_w_last) begin
                        n_col   = '0;
                        n_state = ST_END;
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            ST_END: begin
                o_issue     = i_take;
                o_item.kind = KIND_END;
                if (o_issue) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    assign o_addr     = r_col;
    assign o_rd_en    = o_issue && (o_item.kind != KIND_END);
    assign o_flushing = (r_state != ST_IDLE);

endmodule

`default_nettype wire

// ===== sv/ipr_win.sv =====
// ipr_win: window stage, two held columns plus the column read from line memory
// decides at most one pixel per step, writes the line memory back, forwards same-entry data
// depends on ipr_pkg
`default_nettype none

module ipr_win
    import ipr_pkg::*;
#(
    parameter int CW = 5
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_issue,
    input  wire t_item             i_item,
    input  wire logic [CW-1:0]     i_addr,
    input  wire logic [WORD_W-1:0] i_rd_data,
    input  wire logic              i_out_free,
    output logic                   o_take,
    output logic                   o_res_valid,
    output t_result                o_res,
    output logic                   o_wr_en,
    output logic [CW-1:0]          o_wr_addr,
    output logic [WORD_W-1:0]      o_wr_data
);

    logic              r_b_valid;
    t_item             r_b;
    logic [CW-1:0]     r_b_addr;
    logic              r_fwd;
    logic [WORD_W-1:0] r_fwd_data;
    logic [2:0]        r_col_a;
    t_col              r_col_b;

    logic [WORD_W-1:0] rd;
    logic [PIX_W-1:0]  up_value;
    t_col              in_col;
    logic              nb_edge, nb_norm, nb;
    logic              is_end, is_edge, emit, fire, removed;

    always_comb begin
        rd            = r_fwd ? r_fwd_data : i_rd_data;
        up_value      = rd[WORD_W-1:1];
        in_col.top    = rd[0] && r_b.top_ok;
        in_col.mid    = (up_value != '0) && r_b.mid_ok;
        in_col.bot    = (r_b.value != '0);
        in_col.value  = up_value;

        is_end  = (r_b.kind == KIND_END);
        is_edge = is_end || r_b.col_zero;
        emit    = is_end ? 1'b1 : (r_b.col_zero ? r_b.top_ok : r_b.mid_ok);

        nb_edge = (|r_col_a) || r_col_b.top || r_col_b.bot;
        nb_norm = nb_edge || in_col.top || in_col.mid || in_col.bot;
        nb      = is_edge ? nb_edge : nb_norm;
        removed = (r_col_b.value != '0) && !nb;

        o_res.value   = removed ? '0 : r_col_b.value;
        o_res.removed = removed;
        o_res.last    = is_end;

        fire        = r_b_valid && (!emit || i_out_free);
        o_take      = !r_b_valid || fire;
        o_res_valid = fire && emit;

        o_wr_en   = fire && (r_b.kind == KIND_REAL);
        o_wr_addr = r_b_addr;
        o_wr_data = {r_b.value, (up_value != '0)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
        end else begin
            r_b_valid <= i_issue || (r_b_valid && !fire);
            if (i_issue) begin
                r_fwd <= o_wr_en && (r_b_addr == i_addr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_issue) begin
            r_b        <= i_item;
            r_b_addr   <= i_addr;
            r_fwd_data <= o_wr_data;
        end
        if (fire && !is_end) begin
            r_col_a <= r_b.col_zero ? 3'b000 : {r_col_b.top, r_col_b.mid, r_col_b.bot};
            r_col_b <= in_col;
        end
    end

endmodule

`default_nettype wire

// ===== sv/isolated_pixel_removal.sv =====
// isolated_pixel_removal: removes nonzero pixels with no nonzero 3x3 neighbor.
// Pixels enter in raster order on the input channel (i_in_valid, o_in_stall,
// i_pixel_value); a transfer happens when valid is high and stall is low.
// Filtered pixels leave in raster order on the output channel (o_out_valid,
// i_out_stall, o_out_pixel, o_was_removed, o_frame_last).
// One line memory of MAX_WIDTH words holds the row above and the nonzero marks
// of the row two above; it is read and written back once per column.
// Throughput is one pixel per cycle when neither an output stall nor a flush holds it.
// A pixel's result needs the pixel one row and one column later, then passes the
// window stage register and the output register. After the last pixel of a frame
// the input stalls while the last row is swept out of the line memory.
// When the receiver stalls, the output register holds its result and the
// stall propagates to the input within the same cycle.
// Reset clears the counters and control state and sets the frame to 10x10;
// the line memory is not cleared. Writing either register restarts the frame.
// Registers: frame_width at byte address 0, frame_height at byte address 4.
// depends on ipr_pkg, ipr_ram, ipr_seq, ipr_win
`default_nettype none

module isolated_pixel_removal
    import ipr_pkg::*;
#(
    parameter int MAX_WIDTH  = 32,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [PIX_W-1:0]      i_pixel_value,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [PIX_W-1:0]      o_out_pixel,
    output logic                       o_was_removed,
    output logic                       o_frame_last
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [CFG_W_W-1:0] r_frame_width;
    logic [CFG_H_W-1:0] r_frame_height;
    logic               cfg_wr;
    t_reg_idx           reg_idx;
    logic [CW-1:0]      w_last;
    logic [RW-1:0]      h_last;

    logic               issue, rd_en, take, flushing;
    t_item              item;
    logic [CW-1:0]      rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [CW-1:0]      wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               res_valid, out_free;
    t_result            res;

    logic               r_out_valid;
    t_result            r_out;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_WIDTH;
            r_frame_height <= RESET_HEIGHT;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_W_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_H_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // effective last column and row, out-of-range sizes clamped
    always_comb begin
        if (r_frame_width == '0) begin
            w_last = '0;
        end else if (int'(r_frame_width) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_frame_width - CFG_W_W'(1));
        end
        if (r_frame_height == '0) begin
            h_last = '0;
        end else if (int'(r_frame_height) > MAX_HEIGHT) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(r_frame_height - CFG_H_W'(1));
        end
    end

    ipr_seq #(
        .CW (CW),
        .RW (RW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_restart     (cfg_wr),
        .i_w_last      (w_last),
        .i_h_last      (h_last),
        .i_in_valid    (i_in_valid),
        .i_pixel_value (i_pixel_value),
        .i_take        (take),
        .o_issue       (issue),
        .o_item        (item),
        .o_addr        (rd_addr),
        .o_rd_en       (rd_en),
        .o_flushing    (flushing)
    );

    ipr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ipr_win #(
        .CW (CW)
    ) u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_item      (item),
        .i_addr      (rd_addr),
        .i_rd_data   (rd_data),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = flushing || !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_pixel   = r_out.value;
    assign o_was_removed = r_out.removed;
    assign o_frame_last  = r_out.last;

    // a removed pixel always leaves as background
    a_removed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_was_removed) |-> (o_out_pixel == '0))
        else $error("removed pixel with nonzero value");

    // no pixel transfer while the last row is being swept out
    a_flush_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flushing |-> o_in_stall)
        else $error("input open during frame flush");

    // a result only loads when the output register can take it
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !res_valid)
        else $error("result overwrites a stalled output");

endmodule

`default_nettype wire

// ===== verif/isolated_pixel_removal_test.sv =====
// isolated_pixel_removal_test: self-checking testbench of the isolated pixel removal filter
// a directed table and random frames over both stream channels and the apb port
// depends on ipr_pkg and isolated_pixel_removal
`default_nettype none

module isolated_pixel_removal_test
    import ipr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 10;
    localparam int FRAME_MAX_W = 32;
    localparam int FRAME_MAX_H = 1024;
    localparam int SETTLE      = 2 * FRAME_MAX_W + 16;
    localparam int HOLD_CYCLES = 240;
    localparam int CYCLE_LIMIT = 250000;
    localparam int PRINT_CAP   = 100;
    localparam int NUM_STEPS   = 29;

    typedef logic [FRAME_MAX_W-1:0][PIX_W-1:0] t_row;
    typedef logic [FRAME_MAX_W-1:0]            t_marks;

    typedef enum logic [1:0] {STEP_PIXEL, STEP_WIDTH, STEP_HEIGHT} t_step_op;
    typedef enum int {PLAIN_PHASE, PAUSE_PHASE, HOLD_PHASE} t_phase_kind;

    typedef struct packed {
        t_step_op          op;
        logic [15:0]       value;
        logic              typed;
        t_result           want;
    } t_directed_step;

    localparam t_result NO_RESULT = '0;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic [PIX_W-1:0]      i_pixel_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [PIX_W-1:0]      o_out_pixel;
    logic                  o_was_removed;
    logic                  o_frame_last;

    // filter state mirror
    logic [CFG_W_W-1:0] width_reg  = RESET_WIDTH;
    logic [CFG_H_W-1:0] height_reg = RESET_HEIGHT;
    t_row               upper_vals = '0;
    t_row               cur_vals   = '0;
    t_marks             two_up_marks = '0;
    int                 scan_col = 0;
    int                 scan_row = 0;

    t_result awaited_pixels[$];

    int cycle_count     = 0;
    int mismatch_count  = 0;
    int results_checked = 0;
    int removals_seen   = 0;
    int pixels_in       = 0;
    int frames_done     = 0;
    int reg_writes      = 0;
    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_requests   = 0;
    int hold_seen       = 0;
    int hold_left       = 0;

    t_directed_step directed_steps [NUM_STEPS];

    isolated_pixel_removal dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_value (i_pixel_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_pixel   (o_out_pixel),
        .o_was_removed (o_was_removed),
        .o_frame_last  (o_frame_last)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int clamp_width(input int raw);
        if (raw < 1) return 1;
        if (raw > FRAME_MAX_W) return FRAME_MAX_W;
        return raw;
    endfunction

    function automatic int clamp_height(input int raw);
        if (raw < 1) return 1;
        if (raw > FRAME_MAX_H) return FRAME_MAX_H;
        return raw;
    endfunction

    function automatic void decide_pixel(input bit see_above, input t_marks above,
                                         input t_row center, input bit see_below,
                                         input t_row below, input int prow,
                                         input int pcol, input int w, input int h);
        bit      lit;
        int      dc;
        int      cc;
        t_result res;
        lit = 1'b0;
        for (dc = -1; dc <= 1; dc++) begin
            cc = pcol + dc;
            if (cc >= 0 && cc < w) begin
                if (see_above && above[cc]) lit = 1'b1;
                if (see_below && below[cc] != '0) lit = 1'b1;
                if (dc != 0 && center[cc] != '0) lit = 1'b1;
            end
        end
        res.value   = center[pcol];
        res.removed = 1'b0;
        if (center[pcol] != '0 && !lit) begin
            res.value   = '0;
            res.removed = 1'b1;
        end
        res.last = (prow == h - 1 && pcol == w - 1);
        awaited_pixels.push_back(res);
    endfunction

    function automatic void filter_pixel_in(input logic [PIX_W-1:0] pix);
        int     w;
        int     h;
        int     c;
        int     r;
        int     i;
        t_marks last_marks;
        w = clamp_width(int'(width_reg));
        h = clamp_height(int'(height_reg));
        c = scan_col;
        r = scan_row;
        last_marks = '0;
        if (c >= w) c = 0;
        if (r >= h) r = 0;
        if (c == 0) begin
            if (r >= 2)
                decide_pixel(r >= 3, two_up_marks, upper_vals, 1'b1, cur_vals,
                             r - 2, w - 1, w, h);
            for (i = 0; i < w; i++) two_up_marks[i] = (upper_vals[i] != '0);
            for (i = 0; i < w; i++) upper_vals[i] = cur_vals[i];
        end
        cur_vals[c] = pix;
        if (c > 0 && r >= 1)
            decide_pixel(r >= 2, two_up_marks, upper_vals, 1'b1, cur_vals,
                         r - 1, c - 1, w, h);
        if (r == h - 1 && c == w - 1) begin
            if (h >= 2) begin
                decide_pixel(h >= 3, two_up_marks, upper_vals, 1'b1, cur_vals,
                             h - 2, w - 1, w, h);
                for (i = 0; i < w; i++) last_marks[i] = (upper_vals[i] != '0);
            end
            for (i = 0; i < w; i++)
                decide_pixel(h >= 2, last_marks, cur_vals, 1'b0, cur_vals, h - 1, i, w, h);
            scan_col = 0;
            scan_row = 0;
            frames_done++;
        end else begin
            c++;
            if (c == w) begin
                c = 0;
                r++;
            end
            scan_col = c;
            scan_row = r;
        end
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel(input int density);
        if ($urandom_range(99) >= density) return '0;
        case ($urandom_range(7))
            0: return '1;
            1: return PIX_W'(1);
            default: return PIX_W'($urandom_range(65535, 1));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_value <= pix;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        filter_pixel_in(pix);
        pixels_in++;
    endtask

    // stop offering, wait for every awaited pixel, then let the block settle
    task automatic drain(input int settle);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaited_pixels.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_register(input t_reg_idx idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == REG_FRAME_WIDTH)
            width_reg = data[CFG_W_W-1:0];
        else
            height_reg = data[CFG_H_W-1:0];
        scan_col = 0;
        scan_row = 0;
        reg_writes++;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int target,
                             input t_phase_kind kind);
        int sent;
        int count;
        int w_raw;
        int h_raw;
        int density;
        int k;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent = 0;
        while (sent < target) begin
            case ($urandom_range(3))
                0: density = 10;
                1: density = 30;
                2: density = 60;
                default: density = 95;
            endcase
            case ($urandom_range(11))
                0: begin
                    w_raw = $urandom_range(1) ? 63 : 32;
                    h_raw = $urandom_range(3, 1);
                end
                1: begin
                    w_raw = 0;
                    h_raw = $urandom_range(8, 0);
                end
                2: begin
                    w_raw = $urandom_range(4, 1);
                    h_raw = $urandom_range(1) ? 2047 : 1024;
                end
                3: begin
                    w_raw = $urandom_range(63);
                    h_raw = $urandom_range(4, 0);
                end
                default: begin
                    w_raw = $urandom_range(8, 1);
                    h_raw = $urandom_range(6, 1);
                end
            endcase
            count = clamp_width(w_raw) * clamp_height(h_raw);
            // broken frames: cut short, the next register write restarts the frame
            if (count > 100)
                count = $urandom_range(60, 1);
            else if ($urandom_range(9) == 0)
                count = $urandom_range(count, 1);
            if (sent == 0 && kind == HOLD_PHASE) begin
                w_raw = 32;
                h_raw = 3;
                count = 96;
            end
            if (sent == 0 && kind == PAUSE_PHASE) begin
                w_raw = 16;
                h_raw = 4;
                count = 64;
            end
            if (count > target - sent)
                count = target - sent;
            drain(SETTLE);
            write_register(REG_FRAME_WIDTH, APB_DATA_W'(w_raw));
            write_register(REG_FRAME_HEIGHT, APB_DATA_W'(h_raw));
            for (k = 0; k < count; k++) begin
                if (sent == 0 && kind == HOLD_PHASE && k == 4) hold_requests++;
                if (sent == 0 && kind == PAUSE_PHASE && k == 30) drain(0);
                send_pixel(pick_pixel(density));
            end
            sent += count;
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (awaited_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer, pixel %h", o_out_pixel));
            end else begin
                want = awaited_pixels.pop_front();
                results_checked++;
                if (want.removed) removals_seen++;
                if (o_out_pixel !== want.value)
                    report_mismatch($sformatf("result %0d out_pixel %h, expected %h",
                                              results_checked, o_out_pixel, want.value));
                if (o_was_removed !== want.removed)
                    report_mismatch($sformatf("result %0d was_removed %b, expected %b",
                                              results_checked, o_was_removed, want.removed));
                if (o_frame_last !== want.last)
                    report_mismatch($sformatf("result %0d frame_last %b, expected %b",
                                              results_checked, o_frame_last, want.last));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still awaited",
                 cycle_count, awaited_pixels.size());
        $display("isolated_pixel_removal verification failed");
        $finish;
    end

    initial begin
        directed_steps = '{
            '{STEP_WIDTH,  16'd1,    1'b0, NO_RESULT},
            '{STEP_HEIGHT, 16'd1,    1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b1, '{16'h0000, 1'b0, 1'b1}},
            '{STEP_PIXEL,  16'hFFFF, 1'b1, '{16'h0000, 1'b1, 1'b1}},
            '{STEP_PIXEL,  16'h0001, 1'b1, '{16'h0000, 1'b1, 1'b1}},
            '{STEP_WIDTH,  16'd0,    1'b0, NO_RESULT},
            '{STEP_HEIGHT, 16'd0,    1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h8000, 1'b1, '{16'h0000, 1'b1, 1'b1}},
            '{STEP_WIDTH,  16'd2,    1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0005, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0007, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0009, 1'b0, NO_RESULT},
            '{STEP_WIDTH,  16'd3,    1'b0, NO_RESULT},
            '{STEP_HEIGHT, 16'd3,    1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0001, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0002, 1'b0, NO_RESULT},
            '{STEP_HEIGHT, 16'd3,    1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'hABCD, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT},
            '{STEP_PIXEL,  16'h0000, 1'b0, NO_RESULT}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 14;
        recv_stall_pct = 56;
        foreach (directed_steps[i]) begin
            case (directed_steps[i].op)
                STEP_PIXEL: begin
                    send_pixel(directed_steps[i].value);
                    if (directed_steps[i].typed)
                        awaited_pixels[awaited_pixels.size() - 1] = directed_steps[i].want;
                end
                STEP_WIDTH: begin
                    drain(SETTLE);
                    write_register(REG_FRAME_WIDTH, APB_DATA_W'(directed_steps[i].value));
                end
                default: begin
                    drain(SETTLE);
                    write_register(REG_FRAME_HEIGHT, APB_DATA_W'(directed_steps[i].value));
                end
            endcase
        end

        run_phase(14, 56, 140, PAUSE_PHASE);
        run_phase(56, 14, 140, PLAIN_PHASE);
        run_phase(0, 0, 140, HOLD_PHASE);
        drain(SETTLE);

        $display("covered %0d pixel transfers in, %0d results checked, %0d removals",
                 pixels_in, results_checked, removals_seen);
        $display("%0d complete frames, %0d register writes, %0d mismatches",
                 frames_done, reg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("isolated_pixel_removal verification clean");
        end else begin
            $display("isolated_pixel_removal verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/ipr_pkg.sv
sv/ipr_ram.sv
sv/ipr_seq.sv
sv/ipr_win.sv
sv/isolated_pixel_removal.sv
verif/isolated_pixel_removal_test.sv
